// File: design/gdz_pkg.sv
// gdz_pkg: shared types and constants of the gamepad deadzone event detector
// holds the event kind codes, register indexes, config struct and the queued job word
// no dependencies
package gdz_pkg;

    // event kind codes
    localparam logic [2:0] KIND_PRESS         = 3'd0;
    localparam logic [2:0] KIND_RELEASE       = 3'd1;
    localparam logic [2:0] KIND_LEFT_TRIGGER  = 3'd2;
    localparam logic [2:0] KIND_RIGHT_TRIGGER = 3'd3;
    localparam logic [2:0] KIND_LEFT_STICK    = 3'd4;
    localparam logic [2:0] KIND_RIGHT_STICK   = 3'd5;

    // configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_THRESHOLD    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_STICK_DEADZONE  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_STICK_DEADZONE = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_ENABLE_MASK   = 4'd3;

    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  RESET_TRIGGER_THRESHOLD    = 8'd30;
    localparam logic [14:0] RESET_LEFT_STICK_DEADZONE  = 15'd7849;
    localparam logic [14:0] RESET_RIGHT_STICK_DEADZONE = 15'd8689;
    localparam logic [15:0] RESET_BUTTON_ENABLE_MASK   = 16'hF3FF;

    typedef struct packed {
        logic [7:0]  trigger_threshold;
        logic [14:0] left_stick_deadzone;
        logic [14:0] right_stick_deadzone;
        logic [15:0] button_enable_mask;
    } cfg_t;

    // one classified sample, handed from the front end to the event sequencer
    typedef struct packed {
        logic [15:0]        btn_changed;
        logic [15:0]        btn_level;
        logic               lt_chg;
        logic               rt_chg;
        logic               ls_chg;
        logic               rs_chg;
        logic [7:0]         lt;
        logic [7:0]         rt;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
    } job_t;

    localparam int JOB_W = $bits(job_t);

endpackage

// File: design/gdz_front.sv
// gdz_front: accepts gamepad samples, applies trigger threshold and stick deadzones,
// compares against the previous cleaned sample and queues a job word when anything changed
// depends on gdz_pkg
module gdz_front import gdz_pkg::*; #(
    parameter int BUTTON_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_button_bits,
    input  logic [7:0]         s_left_trigger_raw,
    input  logic [7:0]         s_right_trigger_raw,
    input  logic signed [15:0] s_left_x_raw,
    input  logic signed [15:0] s_left_y_raw,
    input  logic signed [15:0] s_right_x_raw,
    input  logic signed [15:0] s_right_y_raw,
    input  cfg_t               cfg,
    input  logic               job_full,
    output logic               job_push,
    output job_t               job
);

    localparam logic [16:0] COUNT_MASK_W = (17'd1 << BUTTON_COUNT) - 17'd1;
    localparam logic [15:0] COUNT_MASK   = COUNT_MASK_W[15:0];

    // strictly inside plus or minus dz
    function automatic logic in_deadzone(logic signed [15:0] a, logic [14:0] dz);
        logic signed [16:0] a_w;
        logic signed [16:0] d_w;
        a_w = 17'(a);
        d_w = $signed({2'b00, dz});
        return (a_w < d_w) && (a_w > -d_w);
    endfunction

    logic [15:0]        prev_buttons_reg;
    logic [7:0]         prev_lt_reg;
    logic [7:0]         prev_rt_reg;
    logic signed [15:0] prev_lx_reg, prev_ly_reg, prev_rx_reg, prev_ry_reg;

    logic accept;
    logic left_zero, right_zero;
    logic any_change;

    assign s_ready = !job_full;
    assign accept  = s_valid && s_ready;

    assign left_zero  = in_deadzone(s_left_x_raw, cfg.left_stick_deadzone)
                     && in_deadzone(s_left_y_raw, cfg.left_stick_deadzone);
    assign right_zero = in_deadzone(s_right_x_raw, cfg.right_stick_deadzone)
                     && in_deadzone(s_right_y_raw, cfg.right_stick_deadzone);

    always_comb begin
        job.btn_level   = s_button_bits;
        job.btn_changed = (s_button_bits ^ prev_buttons_reg) & cfg.button_enable_mask
                        & COUNT_MASK;
        job.lt = (s_left_trigger_raw  < cfg.trigger_threshold) ? 8'd0 : s_left_trigger_raw;
        job.rt = (s_right_trigger_raw < cfg.trigger_threshold) ? 8'd0 : s_right_trigger_raw;
        job.lx = left_zero  ? 16'sd0 : s_left_x_raw;
        job.ly = left_zero  ? 16'sd0 : s_left_y_raw;
        job.rx = right_zero ? 16'sd0 : s_right_x_raw;
        job.ry = right_zero ? 16'sd0 : s_right_y_raw;
        job.lt_chg = (job.lt != prev_lt_reg);
        job.rt_chg = (job.rt != prev_rt_reg);
        job.ls_chg = (job.lx != prev_lx_reg) || (job.ly != prev_ly_reg);
        job.rs_chg = (job.rx != prev_rx_reg) || (job.ry != prev_ry_reg);
    end

    assign any_change = (|job.btn_changed) || job.lt_chg || job.rt_chg
                     || job.ls_chg || job.rs_chg;
    assign job_push   = accept && any_change;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_buttons_reg <= '0;
            prev_lt_reg      <= '0;
            prev_rt_reg      <= '0;
            prev_lx_reg      <= '0;
            prev_ly_reg      <= '0;
            prev_rx_reg      <= '0;
            prev_ry_reg      <= '0;
        end else if (accept) begin
            prev_buttons_reg <= s_button_bits;
            prev_lt_reg      <= job.lt;
            prev_rt_reg      <= job.rt;
            prev_lx_reg      <= job.lx;
            prev_ly_reg      <= job.ly;
            prev_rx_reg      <= job.rx;
            prev_ry_reg      <= job.ry;
        end
    end

endmodule

// File: design/gdz_queue.sv
// gdz_queue: short first-in first-out queue of job words between front end and sequencer
// generic width and depth, no package dependency
module gdz_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/gdz_back.sv
// gdz_back: event sequencer, takes queued job words and emits one event word per cycle
// while m_ready allows into a registered output stage; depends on gdz_pkg
module gdz_back import gdz_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_empty,
    input  job_t               job,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_event_kind,
    output logic [3:0]         m_button_index,
    output logic signed [15:0] m_value_a,
    output logic signed [15:0] m_value_b,
    output logic               m_last_event
);

    job_t cur_reg, cur_next;
    logic cur_valid_reg, cur_valid_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         kind_reg;
    logic [3:0]         index_reg;
    logic signed [15:0] value_a_reg, value_b_reg;
    logic               last_reg;

    logic               advance;
    logic               cur_free;
    logic [15:0]        lowest;
    logic [3:0]         ev_index;
    logic [2:0]         ev_kind;
    logic signed [15:0] ev_a, ev_b;
    logic               ev_last;
    job_t               after;

    assign advance = cur_valid_reg && (!out_valid_reg || m_ready);

    // lowest pending button bit
    assign lowest = cur_reg.btn_changed & (~cur_reg.btn_changed + 16'd1);

    always_comb begin
        ev_index = '0;
        for (int i = 0; i < 16; i++) begin
            if (lowest[i]) begin
                ev_index = ev_index | 4'(i);
            end
        end
    end

    always_comb begin
        after   = cur_reg;
        ev_kind = KIND_PRESS;
        ev_a    = '0;
        ev_b    = '0;
        if (|cur_reg.btn_changed) begin
            ev_kind = (|(lowest & cur_reg.btn_level)) ? KIND_PRESS : KIND_RELEASE;
            after.btn_changed = cur_reg.btn_changed & ~lowest;
        end else if (cur_reg.lt_chg) begin
            ev_kind = KIND_LEFT_TRIGGER;
            ev_a    = $signed({8'd0, cur_reg.lt});
            after.lt_chg = 1'b0;
        end else if (cur_reg.rt_chg) begin
            ev_kind = KIND_RIGHT_TRIGGER;
            ev_a    = $signed({8'd0, cur_reg.rt});
            after.rt_chg = 1'b0;
        end else if (cur_reg.ls_chg) begin
            ev_kind = KIND_LEFT_STICK;
            ev_a    = cur_reg.lx;
            ev_b    = cur_reg.ly;
            after.ls_chg = 1'b0;
        end else begin
            ev_kind = KIND_RIGHT_STICK;
            ev_a    = cur_reg.rx;
            ev_b    = cur_reg.ry;
            after.rs_chg = 1'b0;
        end
        ev_last = !(|after.btn_changed) && !after.lt_chg && !after.rt_chg
               && !after.ls_chg && !after.rs_chg;
    end

    // a new job may load in the same cycle the last event of the current one leaves
    assign cur_free = !cur_valid_reg || (advance && ev_last);
    assign job_pop  = cur_free && !job_empty;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (job_pop) begin
            cur_next       = job;
            cur_valid_next = 1'b1;
        end else if (advance) begin
            cur_next       = after;
            cur_valid_next = !ev_last;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (advance) begin
            kind_reg    <= ev_kind;
            index_reg   <= (|cur_reg.btn_changed) ? ev_index : 4'd0;
            value_a_reg <= ev_a;
            value_b_reg <= ev_b;
            last_reg    <= ev_last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_kind   = kind_reg;
    assign m_button_index = index_reg;
    assign m_value_a      = value_a_reg;
    assign m_value_b      = value_b_reg;
    assign m_last_event   = last_reg;

endmodule

// File: design/gamepad_deadzone_event_detector.sv
// gamepad_deadzone_event_detector: top level, configuration registers and the
// front end / queue / event sequencer chain; depends on gdz_pkg, gdz_front, gdz_queue, gdz_back
//
// usage
//   s_ channel: one polled gamepad sample per word (buttons, triggers, stick axes)
//   m_ channel: event words, buttons in ascending bit order, then left and right
//     trigger, then left and right stick; m_last_event marks the final event
//     of a sample, a sample with no change produces no word at all
//   cfg channel: register writes (cfg_index, cfg_data), always ready; the user must
//     issue them only while the block is idle (not enforced); an out-of-list index is ignored
// flow
//   an accepted sample word passes the job queue, the current-job register
//   and the output register before its first event shows on m_valid; the
//   sequencer then emits one event per cycle while m_ready allows, a sample
//   yields at most 20 events, and the next sample's events follow without a gap
//   samples are accepted every cycle while the job queue has room, and samples
//   with no change never enter the queue
// reset
//   previous sample clears to zero, config registers take their defaults,
//   queue and output stage empty
// stall
//   when m_ready is low the output word holds, the sequencer waits, and once
//   the queue fills s_ready drops until the receiver drains it
module gamepad_deadzone_event_detector import gdz_pkg::*; #(
    parameter int BUTTON_COUNT = 16,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // sample input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [15:0]            s_button_bits,
    input  logic [7:0]             s_left_trigger_raw,
    input  logic [7:0]             s_right_trigger_raw,
    input  logic signed [15:0]     s_left_x_raw,
    input  logic signed [15:0]     s_left_y_raw,
    input  logic signed [15:0]     s_right_x_raw,
    input  logic signed [15:0]     s_right_y_raw,
    // event output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_event_kind,
    output logic [3:0]             m_button_index,
    output logic signed [15:0]     m_value_a,
    output logic signed [15:0]     m_value_b,
    output logic                   m_last_event,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;

    job_t             front_job;
    job_t             back_job;
    logic             job_push, job_pop, job_full, job_empty;
    logic [JOB_W-1:0] queue_rdata;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_threshold    <= RESET_TRIGGER_THRESHOLD;
            cfg_reg.left_stick_deadzone  <= RESET_LEFT_STICK_DEADZONE;
            cfg_reg.right_stick_deadzone <= RESET_RIGHT_STICK_DEADZONE;
            cfg_reg.button_enable_mask   <= RESET_BUTTON_ENABLE_MASK;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TRIGGER_THRESHOLD: begin
                    cfg_reg.trigger_threshold <= cfg_data[7:0];
                end
                REG_LEFT_STICK_DEADZONE: begin
                    cfg_reg.left_stick_deadzone <= cfg_data[14:0];
                end
                REG_RIGHT_STICK_DEADZONE: begin
                    cfg_reg.right_stick_deadzone <= cfg_data[14:0];
                end
                REG_BUTTON_ENABLE_MASK: begin
                    cfg_reg.button_enable_mask <= cfg_data;
                end
                default: begin
                    // unknown index, nothing written
                end
            endcase
        end
    end

    // front end: cleaning and change detection against the stored sample
    gdz_front #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_button_bits       (s_button_bits),
        .s_left_trigger_raw  (s_left_trigger_raw),
        .s_right_trigger_raw (s_right_trigger_raw),
        .s_left_x_raw        (s_left_x_raw),
        .s_left_y_raw        (s_left_y_raw),
        .s_right_x_raw       (s_right_x_raw),
        .s_right_y_raw       (s_right_y_raw),
        .cfg                 (cfg_reg),
        .job_full            (job_full),
        .job_push            (job_push),
        .job                 (front_job)
    );

    // short job queue decoupling sample intake from event emission
    gdz_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .wdata   (front_job),
        .pop     (job_pop),
        .rdata   (queue_rdata),
        .full    (job_full),
        .empty   (job_empty)
    );

    assign back_job = job_t'(queue_rdata);

    // sequencer: one event word per cycle into the output register while m_ready allows
    gdz_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_empty      (job_empty),
        .job            (back_job),
        .job_pop        (job_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_button_index (m_button_index),
        .m_value_a      (m_value_a),
        .m_value_b      (m_value_b),
        .m_last_event   (m_last_event)
    );

endmodule
